// File: rtl/core/kzm_pkg.sv
// Package for the key-zone mapper: payload structs, operation and status codes,
// and the zone and search-token types shared by the top level and the cell chain.
// Depends on nothing.
`default_nettype none

package kzm_pkg;

  localparam int KZM_NUM_INSTRUMENTS = 8;
  localparam int KZM_ZONES           = 16;

  localparam int NOTE_W     = 7;
  // Slot indexes in the search token are sized for the largest zone count (64).
  localparam int SLOT_IDX_W = 6;
  localparam int DIST_W     = NOTE_W + 1;
  localparam logic [DIST_W-1:0] NOTE_SPAN = DIST_W'(128);

  typedef enum logic [1:0] {
    FUNC_CREATE = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_NOP    = 2'd3
  } kzm_func_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_INSTR = 2'd2,
    STAT_NO_ZONE  = 2'd3
  } kzm_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LAST,
    ST_INJ,
    ST_SCAN,
    ST_FINISH
  } kzm_state_e;

  typedef struct packed {
    kzm_func_e         func;
    logic [2:0]        instrument;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] root_note;
    logic [NOTE_W-1:0] low_note;
    logic [NOTE_W-1:0] high_note;
  } kzm_in_t;

  typedef struct packed {
    kzm_status_e status;
    logic [3:0]  index;
    logic        direct_hit;
  } kzm_out_t;

  typedef struct packed {
    logic [NOTE_W-1:0] low;
    logic [NOTE_W-1:0] high;
    logic [NOTE_W-1:0] root;
  } kzm_entry_t;

  localparam int ENTRY_W = $bits(kzm_entry_t);

  typedef struct packed {
    logic       vld;
    kzm_entry_t entry;
  } kzm_zone_t;

  typedef struct packed {
    logic                  vld;
    logic [NOTE_W-1:0]     note;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic                  found;
    logic [DIST_W-1:0]     best_dist;
    logic [SLOT_IDX_W-1:0] best_idx;
  } kzm_token_t;

endpackage

`default_nettype wire

// File: rtl/core/kzm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module kzm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/core/kzm_cell.sv
// One cell of the zone search chain: holds one zone slot, shifts zones toward
// cell 0 while loading, and updates the search token passing through it.
// Depends on kzm_pkg.
`default_nettype none

module kzm_cell #(
  parameter int SLOT = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              shift_en_i,
  input  wire kzm_pkg::kzm_zone_t  zone_i,
  output kzm_pkg::kzm_zone_t       zone_o,
  input  wire kzm_pkg::kzm_token_t tok_i,
  output kzm_pkg::kzm_token_t      tok_o
);
  import kzm_pkg::*;

  kzm_zone_t         zone_q;
  kzm_token_t        tok_q, tok_d;
  logic              in_rng;
  logic [NOTE_W-1:0] root_gap;

  always_comb begin
    tok_d    = tok_i;
    in_rng   = (tok_i.note >= zone_q.entry.low) && (tok_i.note <= zone_q.entry.high);
    root_gap = (tok_i.note >= zone_q.entry.root) ? (tok_i.note - zone_q.entry.root)
                                                 : (zone_q.entry.root - tok_i.note);
    if (tok_i.vld && zone_q.vld) begin
      if (!tok_i.hit && in_rng) begin
        tok_d.hit     = 1'b1;
        tok_d.hit_idx = SLOT_IDX_W'(SLOT);
      end
      // Strict compare keeps the lower slot on a tie.
      if ({1'b0, root_gap} < tok_i.best_dist) begin
        tok_d.best_dist = {1'b0, root_gap};
        tok_d.best_idx  = SLOT_IDX_W'(SLOT);
        tok_d.found     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= '0;
      tok_q  <= '0;
    end else begin
      tok_q <= tok_d;
      if (shift_en_i) begin
        zone_q <= zone_i;
      end
    end
  end

  assign zone_o = zone_q;
  assign tok_o  = tok_q;

endmodule

`default_nettype wire

// File: rtl/core/kzm_chain.sv
// Row of search cells: zones enter at the last cell and shift toward cell 0,
// the search token enters at cell 0 and leaves from the last cell.
// Depends on kzm_pkg and kzm_cell.
`default_nettype none

module kzm_chain #(
  parameter int ZONES = kzm_pkg::KZM_ZONES
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              shift_en_i,
  input  wire kzm_pkg::kzm_zone_t  zone_i,
  input  wire kzm_pkg::kzm_token_t tok_i,
  output kzm_pkg::kzm_token_t      tok_o
);
  import kzm_pkg::*;

  kzm_zone_t  zone_link [ZONES+1];
  kzm_token_t tok_link  [ZONES+1];

  assign zone_link[ZONES] = zone_i;
  assign tok_link[0]      = tok_i;

  for (genvar k = 0; k < ZONES; k++) begin : g_cell
    kzm_cell #(
      .SLOT(k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_en_i(shift_en_i),
      .zone_i    (zone_link[k+1]),
      .zone_o    (zone_link[k]),
      .tok_i     (tok_link[k]),
      .tok_o     (tok_link[k+1])
    );
  end

  assign tok_o = tok_link[ZONES];

endmodule

`default_nettype wire

// File: rtl/core/key_zone_mapper.sv
// Key-zone mapper top level: instrument and zone bookkeeping, zone RAM and control.
// Create, add, the unused code and a lookup of a missing instrument go straight to
// the finish state. A lookup fills the cell row with ZONES RAM reads, then walks
// the token through ZONES cells. The finish state loads the output register and
// returns to idle for the next item; a result waits only while the output register
// is stalled. Reset clears instrument and zone counts; zone RAM is undefined.
`default_nettype none

module key_zone_mapper #(
  parameter int NUM_INSTRUMENTS = kzm_pkg::KZM_NUM_INSTRUMENTS,
  parameter int ZONES           = kzm_pkg::KZM_ZONES
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire kzm_pkg::kzm_in_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output kzm_pkg::kzm_out_t     out_data_o
);
  import kzm_pkg::*;

  localparam int INST_W = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
  localparam int ICNT_W = $clog2(NUM_INSTRUMENTS + 1);
  localparam int SLOT_W = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int ZCNT_W = $clog2(ZONES + 1);
  localparam int DEPTH  = NUM_INSTRUMENTS * ZONES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  kzm_state_e state_q, state_d;

  logic [ICNT_W-1:0] inst_cnt_q;
  logic [ZCNT_W-1:0] zcnt_q [NUM_INSTRUMENTS];
  logic [INST_W-1:0] lk_inst_q;
  logic [NOTE_W-1:0] note_q;
  logic [ZCNT_W-1:0] n_q;
  logic [SLOT_W-1:0] ld_cnt_q;
  logic [SLOT_W-1:0] rd_slot_q;
  logic              rd_pend_q;
  kzm_out_t          res_q, res_d;
  kzm_out_t          out_q;
  logic              out_valid_q;

  logic              accept, issue, inject, out_load, ld_last, out_free;
  logic              inst_ok, create_ok, add_ok;
  logic [INST_W-1:0] sel;
  logic [INST_W-1:0] new_inst;
  logic [ZCNT_W-1:0] slot;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  kzm_zone_t         tail_zone;
  kzm_token_t        tok_in, tok_out;

  // Request decode.
  assign sel       = INST_W'(in_data_i.instrument);
  assign new_inst  = INST_W'(inst_cnt_q);
  assign inst_ok   = (32'(in_data_i.instrument) < 32'(inst_cnt_q));
  assign create_ok = (32'(inst_cnt_q) < NUM_INSTRUMENTS);
  assign slot      = zcnt_q[sel];
  assign add_ok    = inst_ok && (32'(slot) < ZONES);
  assign wr_addr   = ADDR_W'(32'(sel) * ZONES + 32'(slot));
  assign rd_addr   = ADDR_W'(32'(lk_inst_q) * ZONES + 32'(ld_cnt_q));
  assign ld_last   = (ld_cnt_q == SLOT_W'(ZONES - 1));
  assign out_free  = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.func == FUNC_LOOKUP && inst_ok) begin
            state_d = ST_LOAD;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_LOAD: begin
        if (ld_last) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: state_d = ST_INJ;
      ST_INJ:  state_d = ST_SCAN;
      ST_SCAN: begin
        if (tok_out.vld) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = in_valid_i && (state_q == ST_IDLE);
    issue      = (state_q == ST_LOAD);
    inject     = (state_q == ST_INJ);
    out_load   = (state_q == ST_FINISH) && out_free;
  end

  // Result of the current item.
  always_comb begin
    res_d = res_q;
    if (accept) begin
      res_d = '{status: STAT_OK, index: 4'd0, direct_hit: 1'b0};
      case (in_data_i.func)
        FUNC_CREATE: begin
          if (create_ok) begin
            res_d.index = 4'(inst_cnt_q);
          end else begin
            res_d.status = STAT_FULL;
          end
        end
        FUNC_ADD: begin
          if (!inst_ok) begin
            res_d.status = STAT_NO_INSTR;
          end else if (!add_ok) begin
            res_d.status = STAT_FULL;
          end else begin
            res_d.index = 4'(slot);
          end
        end
        FUNC_LOOKUP: begin
          if (!inst_ok) begin
            res_d.status = STAT_NO_INSTR;
          end
        end
        default: res_d = '{status: STAT_OK, index: 4'd0, direct_hit: 1'b0};
      endcase
    end else if (state_q == ST_SCAN && tok_out.vld) begin
      if (tok_out.hit) begin
        res_d = '{status: STAT_OK, index: tok_out.hit_idx[3:0], direct_hit: 1'b1};
      end else if (tok_out.found) begin
        res_d = '{status: STAT_OK, index: tok_out.best_idx[3:0], direct_hit: 1'b0};
      end else begin
        res_d = '{status: STAT_NO_ZONE, index: 4'd0, direct_hit: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inst_cnt_q  <= '0;
      zcnt_q      <= '{default: '0};
      ld_cnt_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= issue;
      if (accept && in_data_i.func == FUNC_CREATE && create_ok) begin
        zcnt_q[new_inst] <= '0;
        inst_cnt_q       <= inst_cnt_q + 1'b1;
      end
      if (accept && in_data_i.func == FUNC_ADD && add_ok) begin
        zcnt_q[sel] <= slot + 1'b1;
      end
      if (accept) begin
        ld_cnt_q <= '0;
      end else if (issue && !ld_last) begin
        ld_cnt_q <= ld_cnt_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    rd_slot_q <= ld_cnt_q;
    if (accept) begin
      lk_inst_q <= sel;
      note_q    <= in_data_i.note;
      n_q       <= slot;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  kzm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH),
    .AW   (ADDR_W)
  ) u_zone_ram (
    .clk_i    (clk_i),
    .wr_en_i  (accept && in_data_i.func == FUNC_ADD && add_ok),
    .wr_addr_i(wr_addr),
    .wr_data_i({in_data_i.low_note, in_data_i.high_note, in_data_i.root_note}),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Slots at or above the instrument's zone count enter the row as empty cells.
  assign tail_zone.vld   = (32'(rd_slot_q) < 32'(n_q));
  assign tail_zone.entry = rd_data;

  always_comb begin
    tok_in           = '0;
    tok_in.vld       = inject;
    tok_in.note      = note_q;
    tok_in.best_dist = NOTE_SPAN;
  end

  kzm_chain #(
    .ZONES(ZONES)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_en_i(rd_pend_q),
    .zone_i    (tail_zone),
    .tok_i     (tok_in),
    .tok_o     (tok_out)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: test/tb_key_zone_mapper.sv
// Testbench for key_zone_mapper: directed and random create, add, lookup and nop
// requests with sender bursts and receiver stalls, checked against a local table model.
// Depends on kzm_pkg and the key_zone_mapper RTL.
`timescale 1ns / 1ps

module tb_key_zone_mapper;
  import kzm_pkg::*;

  localparam int RANDOM_REQUESTS = 1800;
  localparam int DRAIN_CYCLES    = 2 * KZM_ZONES + 30;

  // Mirror of the zone table that predicts one reply per accepted request.
  class kzm_reply_checker;
    kzm_out_t          pending_replies[$];
    int unsigned       errors;
    int unsigned       instr_made;
    int unsigned       zones_used[KZM_NUM_INSTRUMENTS];
    logic [NOTE_W-1:0] zone_lo[KZM_NUM_INSTRUMENTS][KZM_ZONES];
    logic [NOTE_W-1:0] zone_hi[KZM_NUM_INSTRUMENTS][KZM_ZONES];
    logic [NOTE_W-1:0] zone_rt[KZM_NUM_INSTRUMENTS][KZM_ZONES];

    function kzm_out_t resolve_request(kzm_in_t req);
      kzm_out_t    rep;
      int unsigned slot;
      int unsigned best_dist;
      int unsigned root_gap;
      bit          hit;
      rep = '0;
      rep.status = STAT_OK;
      case (req.func)
        FUNC_CREATE: begin
          if (instr_made >= KZM_NUM_INSTRUMENTS) begin
            rep.status = STAT_FULL;
          end else begin
            zones_used[instr_made] = 0;
            rep.index = 4'(instr_made);
            instr_made++;
          end
        end
        FUNC_ADD: begin
          if (req.instrument >= instr_made) begin
            rep.status = STAT_NO_INSTR;
          end else if (zones_used[req.instrument] >= KZM_ZONES) begin
            rep.status = STAT_FULL;
          end else begin
            slot = zones_used[req.instrument];
            zone_lo[req.instrument][slot] = req.low_note;
            zone_hi[req.instrument][slot] = req.high_note;
            zone_rt[req.instrument][slot] = req.root_note;
            zones_used[req.instrument] = slot + 1;
            rep.index = 4'(slot);
          end
        end
        FUNC_LOOKUP: begin
          if (req.instrument >= instr_made) begin
            rep.status = STAT_NO_INSTR;
          end else if (zones_used[req.instrument] == 0) begin
            rep.status = STAT_NO_ZONE;
          end else begin
            hit = 1'b0;
            for (int i = 0; i < zones_used[req.instrument] && !hit; i++) begin
              if (req.note >= zone_lo[req.instrument][i] &&
                  req.note <= zone_hi[req.instrument][i]) begin
                hit = 1'b1;
                rep.index = 4'(i);
                rep.direct_hit = 1'b1;
              end
            end
            // No covering zone: the nearest root wins, the lower slot on a tie.
            if (!hit) begin
              best_dist = 128;
              for (int i = 0; i < zones_used[req.instrument]; i++) begin
                root_gap = (req.note >= zone_rt[req.instrument][i]) ?
                           req.note - zone_rt[req.instrument][i] :
                           zone_rt[req.instrument][i] - req.note;
                if (root_gap < best_dist) begin
                  best_dist = root_gap;
                  rep.index = 4'(i);
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
      return rep;
    endfunction

    function void note_input(kzm_in_t req);
      pending_replies.push_back(resolve_request(req));
    endfunction

    function void check_result(kzm_out_t got);
      kzm_out_t exp;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply status %0d index %0d hit %0d", $time,
                 got.status, got.index, got.direct_hit);
        errors++;
      end else begin
        exp = pending_replies.pop_front();
        if (got.status !== exp.status || got.index !== exp.index ||
            got.direct_hit !== exp.direct_hit) begin
          $display("%0t: mismatch: exp st %0d idx %0d hit %0d, got st %0d idx %0d hit %0d",
                   $time, exp.status, exp.index, exp.direct_hit,
                   got.status, got.index, got.direct_hit);
          errors++;
        end
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid_q = 1'b0;
  logic     in_stall_o;
  kzm_in_t  in_data_q = '0;
  logic     out_valid_o;
  logic     out_stall_q = 1'b0;
  kzm_out_t out_data_o;

  kzm_reply_checker sb = new();
  int unsigned      burst_left;
  int unsigned      rx_cycle;
  int unsigned      rx_mode;

  key_zone_mapper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid_q),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_q),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic kzm_in_t make_req(kzm_func_e f, int inst, int note, int root,
                                       int lo, int hi);
    kzm_in_t r;
    r.func = f;
    r.instrument = 3'(inst);
    r.note = 7'(note);
    r.root_note = 7'(root);
    r.low_note = 7'(lo);
    r.high_note = 7'(hi);
    return r;
  endfunction

  function automatic kzm_in_t random_request();
    kzm_in_t     r;
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    pick = $urandom_range(0, 99);
    r.instrument = 3'($urandom_range(0, 7));
    if (sb.instr_made > 0 && $urandom_range(0, 9) != 0)
      r.instrument = 3'($urandom_range(0, sb.instr_made - 1));
    r.note = 7'($urandom);
    r.root_note = 7'($urandom);
    r.low_note = 7'($urandom);
    r.high_note = 7'($urandom);
    if (pick < 3) begin
      r.func = FUNC_CREATE;
    end else if (pick < 35) begin
      r.func = FUNC_ADD;
      // Mostly narrow zones so that lookups fall back on the nearest root often.
      lo = $urandom_range(0, 127);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: hi = (lo + $urandom_range(0, 8) > 127) ? 127 :
                               lo + $urandom_range(0, 8);
        6: hi = $urandom_range(0, 127);
        7: begin
          lo = $urandom_range(1, 127);
          hi = $urandom_range(0, lo - 1);
        end
        8: hi = lo;
        default: begin
          lo = $urandom_range(0, 1) ? 0 : lo;
          hi = 127;
        end
      endcase
      r.low_note = 7'(lo);
      r.high_note = 7'(hi);
      if ($urandom_range(0, 1) && hi >= lo)
        r.root_note = 7'($urandom_range(lo, hi));
    end else if (pick < 94) begin
      r.func = FUNC_LOOKUP;
    end else begin
      r.func = FUNC_NOP;
    end
    return r;
  endfunction

  // Holds the request until the block takes it; valid stays high afterwards.
  task automatic send_item(kzm_in_t req);
    in_data_q <= req;
    in_valid_q <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(req);
  endtask

  task automatic send_paced(kzm_in_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid_q <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 5) == 0 ? $urandom_range(60, 120) :
                   $urandom_range(1, 16);
    end
    burst_left--;
    send_item(req);
  endtask

  task automatic wait_drained();
    in_valid_q <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Receiver: checks each transfer and stalls on a pattern that changes now and then.
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && !out_stall_q)
      sb.check_result(out_data_o);
    rx_cycle++;
    if (rx_cycle % 300 == 0)
      rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_stall_q <= 1'b0;
      1: out_stall_q <= ($urandom_range(0, 2) == 0);
      2: out_stall_q <= (rx_cycle % 23) < 9;
      default: out_stall_q <= (rx_cycle % 7) == 0;
    endcase
  end

  initial begin
    kzm_in_t directed_q[$];
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    directed_q.push_back(make_req(FUNC_LOOKUP, 0, 60, 0, 0, 0));
    directed_q.push_back(make_req(FUNC_ADD, 0, 0, 64, 10, 20));
    directed_q.push_back(make_req(FUNC_NOP, 7, 127, 127, 127, 127));
    directed_q.push_back(make_req(FUNC_CREATE, 7, 127, 0, 127, 0));
    directed_q.push_back(make_req(FUNC_LOOKUP, 0, 64, 0, 0, 0));
    // An inverted zone never covers a note but still competes on its root.
    directed_q.push_back(make_req(FUNC_ADD, 0, 0, 50, 60, 40));
    directed_q.push_back(make_req(FUNC_LOOKUP, 0, 45, 0, 0, 0));
    directed_q.push_back(make_req(FUNC_ADD, 0, 127, 0, 0, 0));
    directed_q.push_back(make_req(FUNC_ADD, 0, 0, 127, 127, 127));
    directed_q.push_back(make_req(FUNC_ADD, 0, 0, 90, 10, 20));
    directed_q.push_back(make_req(FUNC_ADD, 0, 0, 30, 100, 90));
    directed_q.push_back(make_req(FUNC_LOOKUP, 0, 0, 127, 127, 127));
    directed_q.push_back(make_req(FUNC_LOOKUP, 0, 127, 0, 0, 0));
    directed_q.push_back(make_req(FUNC_LOOKUP, 0, 15, 0, 0, 0));
    directed_q.push_back(make_req(FUNC_LOOKUP, 0, 40, 0, 0, 0));
    directed_q.push_back(make_req(FUNC_LOOKUP, 0, 110, 0, 0, 0));
    for (int i = 1; i <= KZM_NUM_INSTRUMENTS; i++)
      directed_q.push_back(make_req(FUNC_CREATE, i % 8, i * 15, 0, 0, 0));
    directed_q.push_back(make_req(FUNC_ADD, 7, 0, 64, 0, 127));
    directed_q.push_back(make_req(FUNC_LOOKUP, 7, 1, 0, 0, 0));
    directed_q.push_back(make_req(FUNC_LOOKUP, 5, 64, 0, 0, 0));

    foreach (directed_q[i]) send_paced(directed_q[i]);
    wait_drained();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      send_paced(random_request());
      if (n % 400 == 399)
        wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
